// ===== sv/sda_pkg.sv =====
`default_nettype none
package sda_pkg;

	localparam int COORD_W    = 24;
	localparam int ABS_W      = COORD_W + 1;
	localparam int SQ_W       = 2 * ABS_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int SQRT_STEPS = 25;
	localparam int ROOT_W     = 26;
	localparam int RAD_W      = 24;
	localparam int DIV_STEPS  = 30;
	localparam int LOG_STEPS  = 16;
	localparam int EXP_STEPS  = 16;
	localparam int Q15_W      = 16;

	localparam logic [Q15_W-1:0] Q15_ONE     = 16'd32768;
	localparam logic [Q15_W-1:0] MIN_ROLLOFF = 16'd410;

	typedef enum logic [1:0] {
		SEL_CALC,
		SEL_ONE,
		SEL_ZERO
	} sel_t;

	typedef enum logic [2:0] {
		REG_INNER       = 3'd0,
		REG_OUTER       = 3'd1,
		REG_ROLLOFF     = 3'd2,
		REG_CHAN_GAIN   = 3'd3,
		REG_MASTER_GAIN = 3'd4,
		REG_POS_MODE    = 3'd5
	} reg_idx_t;

	// bitwise integer square root, elaboration use only
	function automatic logic [63:0] isqrt_c(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^(-i)) in Q0.30, by repeated square roots of 0.5
	function automatic logic [29:0] exp_coef(input int i);
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int j = 1; j < 17; j++) begin
			if (j <= i) begin
				c = isqrt_c(c << 30);
			end
		end
		return c[29:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/sda_isqrt.sv =====
`default_nettype none
module sda_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       vld_in,
	input  logic [sda_pkg::SUM_W-1:0]  rad_in,
	output logic                       vld_out,
	output logic [sda_pkg::ROOT_W-1:0] root_out
);

	localparam int N = sda_pkg::SQRT_STEPS;
	localparam int W = sda_pkg::SUM_W;

	logic [W-1:0] v_s [1:N];
	logic [W-1:0] r_s [1:N];
	logic         vld_s [1:N];

	// one result bit per stage, top bit first
	for (genvar s = 0; s < N; s++) begin : g_st
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - s));
		logic [W-1:0] v_i;
		logic [W-1:0] r_i;
		logic [W-1:0] t;
		logic         vi;

		if (s == 0) begin : g_first
			assign v_i = rad_in;
			assign r_i = '0;
			assign vi  = vld_in;
		end else begin : g_next
			assign v_i = v_s[s];
			assign r_i = r_s[s];
			assign vi  = vld_s[s];
		end

		assign t = r_i + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (adv) begin
				vld_s[s+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (v_i >= t) begin
					v_s[s+1] <= v_i - t;
					r_s[s+1] <= (r_i >> 1) + BIT;
				end else begin
					v_s[s+1] <= v_i;
					r_s[s+1] <= r_i >> 1;
				end
			end
		end
	end

	assign vld_out  = vld_s[N];
	assign root_out = r_s[N][sda_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== sv/sda_div.sv =====
`default_nettype none
module sda_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          vld_in,
	input  sda_pkg::sel_t                 sel_in,
	input  logic [sda_pkg::RAD_W-1:0]     num_in,
	input  logic [sda_pkg::RAD_W-1:0]     den_in,
	output logic                          vld_out,
	output sda_pkg::sel_t                 sel_out,
	output logic [sda_pkg::DIV_STEPS-1:0] quo_out
);

	localparam int N = sda_pkg::DIV_STEPS;
	localparam int RW = sda_pkg::RAD_W;

	logic [RW-1:0] rem_s [1:N];
	logic [RW-1:0] den_s [1:N];
	logic [N-1:0]  quo_s [1:N];
	sda_pkg::sel_t sel_s [1:N];
	logic          vld_s [1:N];

	// restoring divide of num * 2^30 by den, num below den
	for (genvar s = 0; s < N; s++) begin : g_st
		logic [RW-1:0] rem_i;
		logic [RW-1:0] den_i;
		logic [N-1:0]  quo_i;
		sda_pkg::sel_t sel_i;
		logic          vi;
		logic [RW:0]   r2;
		logic [RW:0]   diff;
		logic          ge;

		if (s == 0) begin : g_first
			assign rem_i = num_in;
			assign den_i = den_in;
			assign quo_i = '0;
			assign sel_i = sel_in;
			assign vi    = vld_in;
		end else begin : g_next
			assign rem_i = rem_s[s];
			assign den_i = den_s[s];
			assign quo_i = quo_s[s];
			assign sel_i = sel_s[s];
			assign vi    = vld_s[s];
		end

		assign r2   = {rem_i, 1'b0};
		assign ge   = r2 >= {1'b0, den_i};
		assign diff = r2 - {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (adv) begin
				vld_s[s+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[s+1] <= ge ? diff[RW-1:0] : r2[RW-1:0];
				den_s[s+1] <= den_i;
				quo_s[s+1] <= {quo_i[N-2:0], ge};
				sel_s[s+1] <= sel_i;
			end
		end
	end

	assign vld_out = vld_s[N];
	assign sel_out = sel_s[N];
	assign quo_out = quo_s[N];

endmodule
`default_nettype wire

// ===== sv/sound_distance_attenuation_unit.sv =====
// Channel   Dir  Beat fields (lowest bit first)
// s_axis    in   source_x, source_y, source_z, listener_x, listener_y, listener_z
// m_axis    out  attenuation, output_gain
// wr_*      in   register index, data (write on wr_en)
//
// One item per cycle while m_axis is not held; the pipeline holds the 25-stage square root,
// the 30-stage divider and the 16 squaring and 16 exponent multiply stages.
// arst_n clears all valid bits and loads the register reset values.
// A result held on m_axis stalls every stage together; nothing moves or drops.
`default_nettype none
module sound_distance_attenuation_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// source_x, source_y, source_z, listener_x, listener_y, listener_z
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// attenuation, output_gain
	output logic [31:0]  m_axis_tdata,
	input  logic         wr_en,
	input  logic [2:0]   wr_index,
	input  logic [23:0]  wr_data
);

	localparam int CW = sda_pkg::COORD_W;
	localparam int AW = sda_pkg::ABS_W;
	localparam int QW = sda_pkg::Q15_W;
	localparam int LN = sda_pkg::LOG_STEPS;
	localparam int EN = sda_pkg::EXP_STEPS;

	// configuration
	logic [23:0]   inner_q;
	logic [23:0]   outer_q;
	logic [QW-1:0] rolloff_q;
	logic [QW-1:0] chan_gain_q;
	logic [QW-1:0] master_gain_q;
	logic          pos_mode_q;
	logic [QW-1:0] gain_q;
	logic [QW-1:0] wr_v16;
	logic [31:0]   gain_prod;

	assign wr_v16 = wr_data[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q       <= 24'd256;
			outer_q       <= 24'd12800;
			rolloff_q     <= 16'd8192;
			chan_gain_q   <= sda_pkg::Q15_ONE;
			master_gain_q <= sda_pkg::Q15_ONE;
			pos_mode_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (sda_pkg::reg_idx_t'(wr_index))
				sda_pkg::REG_INNER: inner_q <= wr_data;
				sda_pkg::REG_OUTER: outer_q <= wr_data;
				sda_pkg::REG_ROLLOFF: begin
					rolloff_q <= (wr_v16 < sda_pkg::MIN_ROLLOFF) ? sda_pkg::MIN_ROLLOFF : wr_v16;
				end
				sda_pkg::REG_CHAN_GAIN: begin
					chan_gain_q <= (wr_v16 > sda_pkg::Q15_ONE) ? sda_pkg::Q15_ONE : wr_v16;
				end
				sda_pkg::REG_MASTER_GAIN: begin
					master_gain_q <= (wr_v16 > sda_pkg::Q15_ONE) ? sda_pkg::Q15_ONE : wr_v16;
				end
				sda_pkg::REG_POS_MODE: pos_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign gain_prod = master_gain_q * chan_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= sda_pkg::Q15_ONE;
		end else begin
			gain_q <= gain_prod[30:15];
		end
	end

	// global advance: the output register is free or being drained
	logic adv;
	logic vld_s9;
	assign adv = !vld_s9 || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: absolute differences
	logic [AW-1:0] ax_s1, ay_s1, az_s1;
	logic          vld_s1;

	function automatic logic [AW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [AW-1:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		return d[AW-1] ? (~d + AW'(1)) : d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= abs_diff(s_axis_tdata[23:0], s_axis_tdata[95:72]);
			ay_s1 <= abs_diff(s_axis_tdata[47:24], s_axis_tdata[119:96]);
			az_s1 <= abs_diff(s_axis_tdata[71:48], s_axis_tdata[143:120]);
		end
	end

	// stage 2: squares
	logic [sda_pkg::SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic                     vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			sqz_s2 <= az_s1 * az_s1;
		end
	end

	// stage 3: sum of squares
	logic [sda_pkg::SUM_W-1:0] sum_s3;
	logic                      vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2} + {1'b0, sqz_s2};
		end
	end

	logic                       vld_sq;
	logic [sda_pkg::ROOT_W-1:0] root_d;

	sda_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s3),
		.rad_in   (sum_s3),
		.vld_out  (vld_sq),
		.root_out (root_d)
	);

	// stage 4: classify distance against the radii
	logic [23:0]   num_s4, den_s4;
	sda_pkg::sel_t sel_s4;
	logic          vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= outer_q - root_d[23:0];
			den_s4 <= outer_q - inner_q;
			priority if (outer_q == '0 || outer_q <= inner_q || root_d <= {2'b00, inner_q}) begin
				sel_s4 <= sda_pkg::SEL_ONE;
			end else if (root_d >= {2'b00, outer_q}) begin
				sel_s4 <= sda_pkg::SEL_ZERO;
			end else begin
				sel_s4 <= sda_pkg::SEL_CALC;
			end
		end
	end

	logic                          vld_dv;
	sda_pkg::sel_t                 sel_dv;
	logic [sda_pkg::DIV_STEPS-1:0] quo_dv;

	sda_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (vld_s4),
		.sel_in  (sel_s4),
		.num_in  (num_s4),
		.den_in  (den_s4),
		.vld_out (vld_dv),
		.sel_out (sel_dv),
		.quo_out (quo_dv)
	);

	// stage 5: leading one of the ratio
	logic [29:0]   xq_s5;
	logic [4:0]    sh_s5;
	sda_pkg::sel_t sel_s5;
	logic          vld_s5;
	logic [4:0]    lead;

	always_comb begin
		lead = '0;
		for (int b = 1; b < 30; b++) begin
			if (quo_dv[b]) begin
				lead = 5'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xq_s5  <= quo_dv;
			sh_s5  <= 5'd30 - lead;
			sel_s5 <= sel_dv;
		end
	end

	// stage 6: normalize to Q1.30
	logic [30:0]   m_s6;
	logic [4:0]    sh_s6;
	sda_pkg::sel_t sel_s6;
	logic          vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6   <= {1'b0, xq_s5} << sh_s5;
			sh_s6  <= sh_s5;
			sel_s6 <= sel_s5;
		end
	end

	// log2 fraction: one squaring per stage
	logic [30:0]   m_l   [1:LN];
	logic [15:0]   frac_l [1:LN];
	logic [4:0]    sh_l  [1:LN];
	sda_pkg::sel_t sel_l [1:LN];
	logic          vld_l [1:LN];

	for (genvar i = 0; i < LN; i++) begin : g_log
		logic [30:0]   m_i;
		logic [15:0]   frac_i;
		logic [4:0]    sh_i;
		sda_pkg::sel_t sel_i;
		logic          vi;
		logic [61:0]   sq;
		logic [31:0]   t;

		if (i == 0) begin : g_first
			assign m_i    = m_s6;
			assign frac_i = '0;
			assign sh_i   = sh_s6;
			assign sel_i  = sel_s6;
			assign vi     = vld_s6;
		end else begin : g_next
			assign m_i    = m_l[i];
			assign frac_i = frac_l[i];
			assign sh_i   = sh_l[i];
			assign sel_i  = sel_l[i];
			assign vi     = vld_l[i];
		end

		assign sq = m_i * m_i;
		assign t  = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_l[i+1] <= 1'b0;
			end else if (adv) begin
				vld_l[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				m_l[i+1]    <= t[31] ? t[31:1] : t[30:0];
				frac_l[i+1] <= {frac_i[14:0], t[31]};
				sh_l[i+1]   <= sh_i;
				sel_l[i+1]  <= sel_i;
			end
		end
	end

	// stage 7: scale -log2 by the rolloff
	logic [20:0]   neglog;
	logic [36:0]   eprod;
	logic [15:0]   f_s7;
	logic [3:0]    ksh_s7;
	logic          kbig_s7;
	sda_pkg::sel_t sel_s7;
	logic          vld_s7;

	assign neglog = {sh_l[LN], 16'd0} - {5'd0, frac_l[LN]};
	assign eprod  = neglog * rolloff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_l[LN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s7    <= eprod[27:12];
			ksh_s7  <= eprod[31:28];
			kbig_s7 <= |eprod[36:32];
			sel_s7  <= sel_l[LN];
		end
	end

	// exp2 of the fraction: one constant multiply per stage
	logic [30:0]   y_e   [1:EN];
	logic [15:0]   f_e   [1:EN];
	logic [3:0]    ksh_e [1:EN];
	logic          kbig_e [1:EN];
	sda_pkg::sel_t sel_e [1:EN];
	logic          vld_e [1:EN];

	for (genvar i = 0; i < EN; i++) begin : g_exp
		localparam logic [29:0] COEF = sda_pkg::exp_coef(i);
		logic [30:0]   y_i;
		logic [15:0]   f_i;
		logic [3:0]    ksh_i;
		logic          kbig_i;
		sda_pkg::sel_t sel_i;
		logic          vi;
		logic [60:0]   prod;

		if (i == 0) begin : g_first
			assign y_i    = 31'h4000_0000;
			assign f_i    = f_s7;
			assign ksh_i  = ksh_s7;
			assign kbig_i = kbig_s7;
			assign sel_i  = sel_s7;
			assign vi     = vld_s7;
		end else begin : g_next
			assign y_i    = y_e[i];
			assign f_i    = f_e[i];
			assign ksh_i  = ksh_e[i];
			assign kbig_i = kbig_e[i];
			assign sel_i  = sel_e[i];
			assign vi     = vld_e[i];
		end

		assign prod = y_i * COEF;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_e[i+1] <= 1'b0;
			end else if (adv) begin
				vld_e[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				y_e[i+1]    <= f_i[15-i] ? prod[60:30] : y_i;
				f_e[i+1]    <= f_i;
				ksh_e[i+1]  <= ksh_i;
				kbig_e[i+1] <= kbig_i;
				sel_e[i+1]  <= sel_i;
			end
		end
	end

	// stage 8: attenuation
	logic [QW-1:0] att_s8;
	logic          vld_s8;
	logic [30:0]   y_sh;

	assign y_sh = y_e[EN] >> ksh_e[EN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_e[EN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (sel_e[EN])
				sda_pkg::SEL_ONE:  att_s8 <= sda_pkg::Q15_ONE;
				sda_pkg::SEL_ZERO: att_s8 <= '0;
				default:           att_s8 <= kbig_e[EN] ? '0 : y_sh[30:15];
			endcase
		end
	end

	// stage 9: output register with final gain
	logic [QW-1:0] att_s9, gain_s9;
	logic [31:0]   out_prod;

	assign out_prod = gain_q * att_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			att_s9  <= att_s8;
			gain_s9 <= pos_mode_q ? out_prod[30:15] : gain_q;
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = {gain_s9, att_s9};

endmodule
`default_nettype wire

// ===== sv/sda_checker.sv =====
`default_nettype none
module sda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a held result blocks the input side
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_atten_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'd32768))
		else $error("attenuation above unity");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:16] <= 16'd32768))
		else $error("output gain above unity");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled beat changed");

endmodule

bind sound_distance_attenuation_unit sda_checker u_sda_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int PIPE_DEPTH  = 96;
	localparam int CYCLE_LIMIT = 300000;
	localparam int EXP_SLOTS   = 512;

	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] atten;
	} gain_result_t;

	typedef struct {
		logic signed [23:0] sx, sy, sz, lx, ly, lz;
	} positions_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         wr_en;
	logic [2:0]   wr_index;
	logic [23:0]  wr_data;

	// shadow copy of the block's registers
	logic [23:0] sh_inner, sh_outer;
	logic [15:0] sh_rolloff, sh_chan_gain, sh_master_gain;
	logic        sh_pos_mode;

	// expected beats, written at the tail and read at the head
	gain_result_t exp_mem [EXP_SLOTS];
	int  exp_wr;
	int  exp_rd;
	int  mismatches;
	int  cycles;
	int  hold_cycles;
	int  stall_cnt;
	bit  quiet;

	sound_distance_attenuation_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] rem, root, bitv;
		rem = v;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// (num/den)^rolloff via 2^(rolloff * log2(num/den)), Q1.15
	function automatic logic [15:0] rolloff_power(input logic [23:0] num, input logic [23:0] den,
			input logic [15:0] rolloff);
		logic [63:0] ratio, mant, neglog, expo, y, kshift;
		logic [63:0] coef [17];
		logic [15:0] frac, fbits;
		int lead;
		ratio = ({40'd0, num} << 30) / {40'd0, den};
		lead = 29;
		while (lead > 0 && ratio[lead] == 1'b0) lead--;
		mant = ratio << (30 - lead);
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			mant = (mant * mant) >> 30;
			frac = frac << 1;
			if (mant >= (64'd1 << 31)) begin
				frac[0] = 1'b1;
				mant = mant >> 1;
			end
		end
		neglog = 64'(30 - lead) * 64'd65536 - 64'(frac);
		expo = (neglog * 64'(rolloff)) >> 12;
		kshift = expo >> 16;
		fbits = expo[15:0];
		if (kshift >= 16) return 16'd0;
		coef[0] = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) coef[i] = floor_sqrt(coef[i-1] << 30);
		y = 64'd1 << 30;
		for (int i = 0; i < 16; i++) begin
			if (fbits[15-i]) y = (y * coef[i]) >> 30;
		end
		y = y >> kshift;
		return 16'(y >> 15);
	endfunction

	function automatic gain_result_t predict_gain(input positions_t p);
		gain_result_t r;
		longint dx, dy, dz;
		logic [63:0] range_d, g;
		dx = longint'(p.sx) - longint'(p.lx);
		dy = longint'(p.sy) - longint'(p.ly);
		dz = longint'(p.sz) - longint'(p.lz);
		range_d = floor_sqrt(64'(dx*dx + dy*dy + dz*dz));
		if (sh_outer == 0 || sh_outer <= sh_inner || range_d <= 64'(sh_inner))
			r.atten = sda_pkg::Q15_ONE;
		else if (range_d >= 64'(sh_outer))
			r.atten = 16'd0;
		else
			r.atten = rolloff_power(sh_outer - 24'(range_d), sh_outer - sh_inner, sh_rolloff);
		g = (64'(sh_master_gain) * 64'(sh_chan_gain)) >> 15;
		if (sh_pos_mode) g = (g * 64'(r.atten)) >> 15;
		r.gain = g[15:0];
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			sda_pkg::REG_INNER:       sh_inner = value;
			sda_pkg::REG_OUTER:       sh_outer = value;
			sda_pkg::REG_ROLLOFF:
				sh_rolloff = (value[15:0] < sda_pkg::MIN_ROLLOFF) ? sda_pkg::MIN_ROLLOFF
					: value[15:0];
			sda_pkg::REG_CHAN_GAIN:
				sh_chan_gain = (value[15:0] > sda_pkg::Q15_ONE) ? sda_pkg::Q15_ONE : value[15:0];
			sda_pkg::REG_MASTER_GAIN:
				sh_master_gain = (value[15:0] > sda_pkg::Q15_ONE) ? sda_pkg::Q15_ONE : value[15:0];
			sda_pkg::REG_POS_MODE:    sh_pos_mode = value[0];
			default: ;
		endcase
	endtask

	// drop valid and wait for every expected beat plus the pipeline depth
	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic send_positions(input positions_t p);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		gap = quiet ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.lz, p.ly, p.lx, p.sz, p.sy, p.sx};
		do @(posedge clk); while (!s_axis_tready);
		exp_mem[exp_wr % EXP_SLOTS] = predict_gain(p);
		exp_wr++;
	endtask

	function automatic positions_t make_positions(input logic signed [23:0] sx, sy, sz, lx, ly, lz);
		positions_t p;
		p.sx = sx; p.sy = sy; p.sz = sz; p.lx = lx; p.ly = ly; p.lz = lz;
		return p;
	endfunction

	// source somewhere around the listener, mostly inside the rolloff band
	function automatic positions_t random_positions(input bit noise);
		positions_t p;
		int span;
		if (noise) return make_positions(24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom), 24'($urandom), 24'($urandom));
		span = (sh_outer > 24'(1 << 21)) ? (1 << 21) : int'(sh_outer) * 3 / 5 + 2;
		p.lx = $signed(24'($urandom_range(0, 1 << 23))) >>> 1;
		p.ly = $signed(24'($urandom_range(0, 1 << 23))) >>> 1;
		p.lz = $signed(24'($urandom_range(0, 1 << 23))) >>> 1;
		p.sx = p.lx + 24'($urandom_range(0, 2 * span) - span);
		p.sy = p.ly + 24'($urandom_range(0, 2 * span) - span);
		p.sz = p.lz + 24'($urandom_range(0, 2 * span) - span);
		return p;
	endfunction

	task automatic test_distance_edges;
		write_reg(sda_pkg::REG_POS_MODE, 24'd1);
		send_positions(make_positions(0, 0, 0, 0, 0, 0));
		send_positions(make_positions(256, 0, 0, 0, 0, 0));
		send_positions(make_positions(257, 0, 0, 0, 0, 0));
		send_positions(make_positions(0, -6400, 0, 0, 0, 0));
		send_positions(make_positions(0, 0, 12799, 0, 0, 0));
		send_positions(make_positions(12800, 0, 0, 0, 0, 0));
		send_positions(make_positions(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
		send_positions(make_positions(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
		send_positions(make_positions(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
		send_positions(make_positions(3000, 4000, -5000, -1000, 2000, 100));
		drain();
	endtask

	task automatic test_register_extremes;
		write_reg(sda_pkg::REG_ROLLOFF, 24'd0);
		write_reg(sda_pkg::REG_CHAN_GAIN, 24'hFFFFFF);
		write_reg(sda_pkg::REG_MASTER_GAIN, 24'd40000);
		write_reg(REG_SPARE_A, 24'd5);
		write_reg(REG_SPARE_B, 24'hFFFFFF);
		send_positions(make_positions(6000, 0, 0, 0, 0, 0));
		send_positions(make_positions(0, 12000, 0, 0, 0, 0));
		drain();
		write_reg(sda_pkg::REG_ROLLOFF, 24'hFFFFFF);
		write_reg(sda_pkg::REG_CHAN_GAIN, 24'd0);
		write_reg(sda_pkg::REG_MASTER_GAIN, 24'd1);
		send_positions(make_positions(300, 0, 0, 0, 0, 0));
		send_positions(make_positions(1000, 0, 0, 0, 0, 0));
		drain();
		write_reg(sda_pkg::REG_CHAN_GAIN, 24'd32768);
		write_reg(sda_pkg::REG_MASTER_GAIN, 24'd32767);
		write_reg(sda_pkg::REG_INNER, 24'hFFFFFF);
		write_reg(sda_pkg::REG_OUTER, 24'd0);
		send_positions(make_positions(0, 5, 0, 0, 0, 0));
		drain();
		write_reg(sda_pkg::REG_INNER, 24'd5000);
		write_reg(sda_pkg::REG_OUTER, 24'd5000);
		send_positions(make_positions(9000, 0, 0, 0, 0, 0));
		drain();
		write_reg(sda_pkg::REG_INNER, 24'd0);
		write_reg(sda_pkg::REG_OUTER, 24'hFFFFFF);
		write_reg(sda_pkg::REG_POS_MODE, 24'hFFFFFE);
		send_positions(make_positions(8388607, 0, 0, -8388608, 0, 0));
		send_positions(make_positions(1, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_random_settings;
		for (int phase = 0; phase < 8; phase++) begin
			quiet = (phase == 3);
			write_reg(sda_pkg::REG_INNER, (phase % 4 == 0) ? 24'd0 : 24'($urandom_range(0, 4000)));
			write_reg(sda_pkg::REG_OUTER,
				(phase == 5) ? 24'hFFFFFF : 24'($urandom_range(1000, 1 << 20)));
			write_reg(sda_pkg::REG_ROLLOFF, (phase == 2) ? 24'd410 : 24'($urandom));
			write_reg(sda_pkg::REG_CHAN_GAIN,
				($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 32768)));
			write_reg(sda_pkg::REG_MASTER_GAIN,
				($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 32768)));
			write_reg(sda_pkg::REG_POS_MODE,
				(phase == 6) ? 24'd0 : 24'($urandom_range(1, 7) | 1));
			for (int n = 0; n < 35; n++) send_positions(random_positions($urandom_range(0, 9) == 0));
			drain();
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure;
		write_reg(sda_pkg::REG_INNER, 24'd100);
		write_reg(sda_pkg::REG_OUTER, 24'd200000);
		write_reg(sda_pkg::REG_POS_MODE, 24'd1);
		quiet = 1'b1;
		@(negedge clk);
		hold_cycles = 400;
		for (int n = 0; n < 150; n++) send_positions(random_positions(1'b0));
		quiet = 1'b0;
		drain();
	endtask

	// results are accepted here apart from hold-off and random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			int r;
			r = $urandom_range(0, 99);
			if (!quiet && r < 8) begin
				stall_cnt <= $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else if (!quiet && r < 10) begin
				stall_cnt <= $urandom_range(15, 50);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			gain_result_t want, got;
			got = m_axis_tdata;
			if (exp_wr == exp_rd) begin
				mismatches++;
				$display("%0t unexpected beat: expected none, actual %h", $realtime, got);
			end else begin
				want = exp_mem[exp_rd % EXP_SLOTS];
				exp_rd++;
				if (got.atten !== want.atten) begin
					mismatches++;
					$display("%0t attenuation: expected %0d, actual %0d",
						$realtime, want.atten, got.atten);
				end
				if (got.gain !== want.gain) begin
					mismatches++;
					$display("%0t output_gain: expected %0d, actual %0d",
						$realtime, want.gain, got.gain);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		exp_wr = 0;
		exp_rd = 0;
		mismatches = 0;
		cycles = 0;
		hold_cycles = 0;
		stall_cnt = 0;
		quiet = 1'b0;
		sh_inner = 24'd256;
		sh_outer = 24'd12800;
		sh_rolloff = 16'd8192;
		sh_chan_gain = sda_pkg::Q15_ONE;
		sh_master_gain = sda_pkg::Q15_ONE;
		sh_pos_mode = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_positions(make_positions(1000, 0, 0, 0, 0, 0));
		drain();
		test_distance_edges();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		drain();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
